[rtl/core/y86_pkg.sv]
// Shared types, constants and helper functions of the Y86-64 instruction executor.
package y86_pkg;

   localparam int MEM_BYTES = 1048576;
   localparam int QUADS     = MEM_BYTES / 8;
   localparam int QA_W      = $clog2(QUADS);
   localparam int NREG      = 15;

   localparam logic [3:0] REG_RSP  = 4'd4;
   localparam logic [3:0] REG_NONE = 4'd15;

   localparam logic [3:0] OP_HALT  = 4'h0;
   localparam logic [3:0] OP_NOP   = 4'h1;
   localparam logic [3:0] OP_CMOV  = 4'h2;
   localparam logic [3:0] OP_IRMOV = 4'h3;
   localparam logic [3:0] OP_RMMOV = 4'h4;
   localparam logic [3:0] OP_MRMOV = 4'h5;
   localparam logic [3:0] OP_ALU   = 4'h6;
   localparam logic [3:0] OP_JUMP  = 4'h7;
   localparam logic [3:0] OP_CALL  = 4'h8;
   localparam logic [3:0] OP_RET   = 4'h9;
   localparam logic [3:0] OP_PUSH  = 4'hA;
   localparam logic [3:0] OP_POP   = 4'hB;

   localparam logic [3:0] ALU_ADD = 4'd0;
   localparam logic [3:0] ALU_SUB = 4'd1;
   localparam logic [3:0] ALU_AND = 4'd2;
   localparam logic [3:0] ALU_XOR = 4'd3;

   localparam logic [3:0] CC_ALWAYS = 4'd0;
   localparam logic [3:0] CC_LE     = 4'd1;
   localparam logic [3:0] CC_LT     = 4'd2;
   localparam logic [3:0] CC_EQ     = 4'd3;
   localparam logic [3:0] CC_NE     = 4'd4;
   localparam logic [3:0] CC_GE     = 4'd5;
   localparam logic [3:0] CC_GT     = 4'd6;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_HALT = 2'd1;
   localparam logic [1:0] STAT_INS  = 2'd2;
   localparam logic [1:0] STAT_ADR  = 2'd3;

   localparam logic [63:0] RSP_RESET = 64'(MEM_BYTES / 2) & ~64'd7;
   localparam logic [63:0] ADDR_MAX  = 64'(MEM_BYTES - 8);

   typedef struct packed {
      logic [7:0]  operation;
      logic [7:0]  reg_byte;
      logic [63:0] immediate;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] next_pc;
      logic [3:0]  dest_reg;
      logic [63:0] dest_value;
      logic        zero_flag;
      logic        sign_flag;
      logic        overflow_flag;
      logic        mem_written;
      logic [19:0] mem_address;
   } rsp_type;

   // Flags are kept as {OF, SF, ZF}.
   typedef struct packed {
      rsp_type         result;
      logic            reg_we;
      logic [3:0]      reg_idx;
      logic [63:0]     reg_val;
      logic            rsp_we;
      logic [63:0]     rsp_val;
      logic [2:0]      flags;
      logic            mem_we;
      logic [QA_W-1:0] mem_idx;
      logic [63:0]     mem_data;
   } exec_type;

   function automatic logic addr_ok(input logic [63:0] a);
      return (a[2:0] == 3'd0) && (a <= ADDR_MAX);
   endfunction

   function automatic logic [QA_W-1:0] quad_idx(input logic [63:0] a);
      return a[QA_W+2:3];
   endfunction

endpackage

[rtl/core/y86_64_instruction_executor.sv]
// Top level of the Y86-64 instruction executor: handshakes, architectural state, memories.
//
// Each request carries one decoded Y86-64 instruction and yields exactly one
// response with its status, next pc, register writeback, flags and any store.
// A request is handled in two steps: when it is accepted, the register RAM is
// read at rA and rB and the data memory is read at the load address (the
// immediate for mrmovq, rsp for popq and ret); then the execute logic uses
// that registered read data, writes back registers, flags, pc and memory, and
// loads the output register. The memories have registered reads, and the block
// takes no new request until the current one has written back. Because
// write-back finishes before the next read is issued, no forwarding is needed.
// A response waiting in the output register does not block the next request;
// only a second finished result with the first still stalled holds the block.
// Registers read as zero after reset, rsp reads as half the memory size, and
// the data memory is undefined until written. Status codes: 0 ok, 1 halt,
// 2 invalid instruction or register, 3 address error; a failed request changes
// no state and reports the current pc.
module y86_64_instruction_executor (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  y86_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output y86_pkg::rsp_type rsp_payload
);
   import y86_pkg::*;

   logic        busy_ff, busy_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff;
   req_type     inst_ff;
   logic [63:0] rsp_ff, pc_ff;
   logic [2:0]  flags_ff;
   logic        accept, done;
   logic [63:0] rd_a_data, rd_b_data, mem_rdata, va, vb, load_addr;
   exec_type    ex;

   assign accept = req_valid && !busy_ff;
   // The executing request retires once the output register can take its result.
   assign done   = busy_ff && (!out_valid_ff || !rsp_stall);

   assign load_addr = (req_payload.operation[7:4] == OP_MRMOV) ? req_payload.immediate
                                                                : rsp_ff;

   y86_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_a      (req_payload.reg_byte[7:4]),
      .rd_b      (req_payload.reg_byte[3:0]),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (done && ex.reg_we),
      .wr_idx    (ex.reg_idx),
      .wr_data   (ex.reg_val)
   );

   y86_dmem u_dmem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_idx  (quad_idx(load_addr)),
      .rd_data (mem_rdata),
      .wr_en   (done && ex.mem_we),
      .wr_idx  (ex.mem_idx),
      .wr_data (ex.mem_data)
   );

   // The stack pointer lives in its own register, so it is substituted here.
   assign va = (inst_ff.reg_byte[7:4] == REG_RSP) ? rsp_ff : rd_a_data;
   assign vb = (inst_ff.reg_byte[3:0] == REG_RSP) ? rsp_ff : rd_b_data;

   y86_exec u_exec (
      .inst      (inst_ff),
      .va        (va),
      .vb        (vb),
      .rsp       (rsp_ff),
      .mem_rdata (mem_rdata),
      .flags     (flags_ff),
      .pc        (pc_ff),
      .ex        (ex)
   );

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (done) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         rsp_ff       <= RSP_RESET;
         pc_ff        <= 64'd0;
         flags_ff     <= 3'd0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         if (done) begin
            pc_ff    <= ex.result.next_pc;
            flags_ff <= ex.flags;
            if (ex.rsp_we) begin
               rsp_ff <= ex.rsp_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         inst_ff <= req_payload;
      end
      if (done) begin
         out_ff <= ex.result;
      end
   end

   assign req_stall   = busy_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

[rtl/core/y86_regs.sv]
// General register storage: a 15-entry RAM with two registered read ports.
module y86_regs (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [3:0]  rd_a,
   input  logic [3:0]  rd_b,
   output logic [63:0] rd_a_data,
   output logic [63:0] rd_b_data,
   input  logic        wr_en,
   input  logic [3:0]  wr_idx,
   input  logic [63:0] wr_data
);
   import y86_pkg::*;

   logic [63:0]     mem [0:NREG-1];
   logic [NREG-1:0] valid_ff, valid_in;
   logic [63:0]     a_data_ff, b_data_ff;
   logic            a_ok_ff, b_ok_ff;

   // An entry never written reads as zero, as after reset.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en && wr_idx != REG_NONE) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         a_ok_ff  <= 1'b0;
         b_ok_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            a_ok_ff <= (rd_a != REG_NONE) ? valid_ff[rd_a] : 1'b0;
            b_ok_ff <= (rd_b != REG_NONE) ? valid_ff[rd_b] : 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_idx != REG_NONE) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en && rd_a != REG_NONE) begin
         a_data_ff <= mem[rd_a];
      end
      if (rd_en && rd_b != REG_NONE) begin
         b_data_ff <= mem[rd_b];
      end
   end

   assign rd_a_data = a_ok_ff ? a_data_ff : 64'd0;
   assign rd_b_data = b_ok_ff ? b_data_ff : 64'd0;

endmodule

[rtl/core/y86_dmem.sv]
// Data memory: one quad per entry, one write port and one registered read port.
module y86_dmem (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [y86_pkg::QA_W-1:0] rd_idx,
   output logic [63:0]              rd_data,
   input  logic                     wr_en,
   input  logic [y86_pkg::QA_W-1:0] wr_idx,
   input  logic [63:0]              wr_data
);
   import y86_pkg::*;

   logic [63:0] mem [0:QUADS-1];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/y86_exec.sv]
// Execute stage: decodes one instruction and computes its result and state updates.
module y86_exec (
   input  y86_pkg::req_type  inst,
   input  logic [63:0]       va,
   input  logic [63:0]       vb,
   input  logic [63:0]       rsp,
   input  logic [63:0]       mem_rdata,
   input  logic [2:0]        flags,
   input  logic [63:0]       pc,
   output y86_pkg::exec_type ex
);
   import y86_pkg::*;

   logic [3:0]  code, fn, ra, rb;
   logic        inval, cond, zf, sf, of, alu_of;
   logic [63:0] imm, rsp_dn, alu_r;
   logic [1:0]  status;
   logic [63:0] npc, dval;
   logic [3:0]  dreg;
   logic        wmem;
   logic [63:0] maddr, mdata;

   assign code   = inst.operation[7:4];
   assign fn     = inst.operation[3:0];
   assign ra     = inst.reg_byte[7:4];
   assign rb     = inst.reg_byte[3:0];
   assign imm    = inst.immediate;
   assign zf     = flags[0];
   assign sf     = flags[1];
   assign of     = flags[2];
   assign rsp_dn = rsp - 64'd8;

   always_comb begin
      unique case (fn)
         CC_ALWAYS: cond = 1'b1;
         CC_LE:     cond = (sf != of) || zf;
         CC_LT:     cond = sf != of;
         CC_EQ:     cond = zf;
         CC_NE:     cond = !zf;
         CC_GE:     cond = sf == of;
         default:   cond = (sf == of) && !zf;
      endcase
   end

   always_comb begin
      alu_of = 1'b0;
      unique case (fn)
         ALU_ADD: begin
            alu_r  = vb + va;
            alu_of = (va[63] ^ alu_r[63]) & (vb[63] ^ alu_r[63]);
         end
         ALU_SUB: begin
            alu_r  = vb - va;
            alu_of = (vb[63] ^ va[63]) & (vb[63] ^ alu_r[63]);
         end
         ALU_AND: alu_r = vb & va;
         default: alu_r = vb ^ va;
      endcase
   end

   always_comb begin
      unique case (code)
         OP_CMOV, OP_JUMP: inval = fn > 4'd6;
         OP_ALU:           inval = fn > 4'd3;
         OP_HALT, OP_NOP, OP_IRMOV, OP_RMMOV, OP_MRMOV, OP_CALL, OP_RET, OP_PUSH, OP_POP:
            inval = fn != 4'd0;
         default:          inval = 1'b1;
      endcase
      if ((code == OP_CMOV || code == OP_ALU) && (ra == REG_NONE || rb == REG_NONE)) begin
         inval = 1'b1;
      end
      if (code == OP_IRMOV && rb == REG_NONE) begin
         inval = 1'b1;
      end
      if ((code == OP_RMMOV || code == OP_MRMOV || code == OP_PUSH || code == OP_POP)
          && ra == REG_NONE) begin
         inval = 1'b1;
      end
   end

   always_comb begin
      status    = STAT_OK;
      npc       = pc;
      dreg      = REG_NONE;
      dval      = 64'd0;
      wmem      = 1'b0;
      maddr     = 64'd0;
      mdata     = va;
      ex.flags  = flags;
      ex.rsp_we = 1'b0;
      ex.rsp_val = rsp + 64'd8;
      if (inval) begin
         status = STAT_INS;
      end else begin
         unique case (code)
            OP_HALT: begin
               status = STAT_HALT;
               npc    = pc + 64'd1;
            end
            OP_NOP: npc = pc + 64'd1;
            OP_CMOV: begin
               npc = pc + 64'd2;
               if (cond) begin
                  dreg = rb;
                  dval = va;
               end
            end
            OP_IRMOV: begin
               npc  = pc + 64'd10;
               dreg = rb;
               dval = imm;
            end
            OP_RMMOV: begin
               if (!addr_ok(imm)) begin
                  status = STAT_ADR;
               end else begin
                  npc   = pc + 64'd10;
                  wmem  = 1'b1;
                  maddr = imm;
               end
            end
            OP_MRMOV: begin
               if (!addr_ok(imm)) begin
                  status = STAT_ADR;
               end else begin
                  npc  = pc + 64'd10;
                  dreg = ra;
                  dval = mem_rdata;
               end
            end
            OP_ALU: begin
               ex.flags = {alu_of, alu_r[63], alu_r == 64'd0};
               npc      = pc + 64'd2;
               dreg     = rb;
               dval     = alu_r;
            end
            OP_JUMP: npc = cond ? imm : pc + 64'd9;
            OP_CALL: begin
               if (!addr_ok(rsp_dn)) begin
                  status = STAT_ADR;
               end else begin
                  wmem  = 1'b1;
                  maddr = rsp_dn;
                  mdata = pc + 64'd9;
                  dreg  = REG_RSP;
                  dval  = rsp_dn;
                  npc   = imm;
               end
            end
            OP_RET: begin
               if (!addr_ok(rsp)) begin
                  status = STAT_ADR;
               end else begin
                  npc  = mem_rdata;
                  dreg = REG_RSP;
                  dval = rsp + 64'd8;
               end
            end
            OP_PUSH: begin
               if (!addr_ok(rsp_dn)) begin
                  status = STAT_ADR;
               end else begin
                  wmem  = 1'b1;
                  maddr = rsp_dn;
                  dreg  = REG_RSP;
                  dval  = rsp_dn;
                  npc   = pc + 64'd2;
               end
            end
            OP_POP: begin
               if (!addr_ok(rsp)) begin
                  status = STAT_ADR;
               end else begin
                  ex.rsp_we = 1'b1;
                  dreg      = ra;
                  dval      = mem_rdata;
                  npc       = pc + 64'd2;
               end
            end
            default: status = STAT_INS;
         endcase
      end
      // A destination of rsp overrides the pop increment.
      if (dreg == REG_RSP) begin
         ex.rsp_we  = 1'b1;
         ex.rsp_val = dval;
      end
      ex.reg_we   = (dreg != REG_NONE) && (dreg != REG_RSP);
      ex.reg_idx  = dreg;
      ex.reg_val  = dval;
      ex.mem_we   = wmem;
      ex.mem_idx  = quad_idx(maddr);
      ex.mem_data = mdata;
      ex.result.status        = status;
      ex.result.next_pc       = npc;
      ex.result.dest_reg      = dreg;
      ex.result.dest_value    = dval;
      ex.result.zero_flag     = ex.flags[0];
      ex.result.sign_flag     = ex.flags[1];
      ex.result.overflow_flag = ex.flags[2];
      ex.result.mem_written   = wmem;
      ex.result.mem_address   = maddr[19:0];
   end

endmodule

[rtl/core/y86_checker.sv]
// Port-level checker for the Y86-64 instruction executor, bound to the top level.
module y86_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input y86_pkg::rsp_type rsp_payload
);
   import y86_pkg::*;

   // A response that is stalled stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // An accepted request holds off the next one in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted in back-to-back cycles");

   // After an accepted request has gone through its execute state, a response is on
   // offer: either its own result or an older one still waiting in the output register.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("no response after accepted request");

   // A failed instruction neither writes a register nor stores to memory.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STAT_INS || rsp_payload.status == STAT_ADR)
      |-> rsp_payload.dest_reg == REG_NONE && !rsp_payload.mem_written)
      else $error("failed instruction reports a side effect");

endmodule

bind y86_64_instruction_executor y86_checker u_y86_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[dv/tb_top.sv]
// Self-checking testbench of the Y86-64 instruction executor.
`timescale 1ns / 1ps

module tb_top;
   import y86_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   y86_64_instruction_executor u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // The predictor keeps its own copy of the architectural state.
   logic [63:0] arch_regs [0:14];
   logic [2:0]  arch_flags;   // {OF, SF, ZF}
   logic [63:0] arch_pc;
   logic [63:0] arch_mem [logic [63:0]];

   // Expected responses, oldest first.
   rsp_type expected_rsps [$];
   int      error_count;
   bit      hold_rsp;        // set while the receiver holds off on purpose

   // Quads that have been stored, so loads only ever touch written memory.
   logic [63:0] stored_addrs [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit: far beyond the slowest correct run.
   initial begin
      #20ms;
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic bit cond_true(input logic [3:0] fn);
      logic zf, sf, of;
      zf = arch_flags[0];
      sf = arch_flags[1];
      of = arch_flags[2];
      case (fn)
         CC_ALWAYS: return 1'b1;
         CC_LE:     return (sf != of) || zf;
         CC_LT:     return sf != of;
         CC_EQ:     return zf;
         CC_NE:     return !zf;
         CC_GE:     return sf == of;
         default:   return (sf == of) && !zf;
      endcase
   endfunction

   function automatic bit quad_ok(input logic [63:0] a);
      return (a[2:0] == 3'd0) && (a <= 64'(MEM_BYTES - 8));
   endfunction

   function automatic logic [63:0] mem_read(input logic [63:0] a);
      if (arch_mem.exists(a)) return arch_mem[a];
      return 64'd0;
   endfunction

   // Executes one instruction on the predictor state and returns its response.
   function automatic rsp_type execute_instr(input req_type rq);
      rsp_type     r;
      logic [3:0]  code, fn, ra, rb;
      logic [63:0] va, vb, rsp, res, addr;
      bit          bad;
      bit          of;
      code = rq.operation[7:4];
      fn   = rq.operation[3:0];
      ra   = rq.reg_byte[7:4];
      rb   = rq.reg_byte[3:0];
      va   = (ra != REG_NONE) ? arch_regs[ra] : 64'd0;
      vb   = (rb != REG_NONE) ? arch_regs[rb] : 64'd0;
      rsp  = arch_regs[REG_RSP];
      r    = '0;
      r.status   = STAT_OK;
      r.next_pc  = arch_pc;
      r.dest_reg = REG_NONE;
      case (code)
         OP_CMOV, OP_JUMP: bad = fn > 4'd6;
         OP_ALU:           bad = fn > 4'd3;
         OP_HALT, OP_NOP, OP_IRMOV, OP_RMMOV, OP_MRMOV, OP_CALL, OP_RET, OP_PUSH,
         OP_POP:           bad = fn != 4'd0;
         default:          bad = 1'b1;
      endcase
      if (!bad) begin
         if ((code == OP_CMOV || code == OP_ALU) && (ra == REG_NONE || rb == REG_NONE))
            bad = 1'b1;
         if (code == OP_IRMOV && rb == REG_NONE) bad = 1'b1;
         if ((code == OP_RMMOV || code == OP_MRMOV || code == OP_PUSH || code == OP_POP)
             && ra == REG_NONE)
            bad = 1'b1;
      end
      if (bad) begin
         r.status = STAT_INS;
      end else begin
         case (code)
            OP_HALT: begin
               r.status  = STAT_HALT;
               r.next_pc = arch_pc + 64'd1;
            end
            OP_NOP: r.next_pc = arch_pc + 64'd1;
            OP_CMOV: begin
               r.next_pc = arch_pc + 64'd2;
               if (cond_true(fn)) begin
                  r.dest_reg   = rb;
                  r.dest_value = va;
               end
            end
            OP_IRMOV: begin
               r.next_pc    = arch_pc + 64'd10;
               r.dest_reg   = rb;
               r.dest_value = rq.immediate;
            end
            OP_RMMOV: begin
               if (!quad_ok(rq.immediate)) r.status = STAT_ADR;
               else begin
                  r.next_pc     = arch_pc + 64'd10;
                  r.mem_written = 1'b1;
                  r.mem_address = rq.immediate[19:0];
                  arch_mem[rq.immediate] = va;
               end
            end
            OP_MRMOV: begin
               if (!quad_ok(rq.immediate)) r.status = STAT_ADR;
               else begin
                  r.next_pc    = arch_pc + 64'd10;
                  r.dest_reg   = ra;
                  r.dest_value = mem_read(rq.immediate);
               end
            end
            OP_ALU: begin
               of = 1'b0;
               case (fn)
                  ALU_ADD: begin
                     res = vb + va;
                     of  = va[63] == vb[63] && res[63] != va[63];
                  end
                  ALU_SUB: begin
                     res = vb - va;
                     of  = vb[63] != va[63] && res[63] != vb[63];
                  end
                  ALU_AND: res = vb & va;
                  default: res = vb ^ va;
               endcase
               arch_flags   = {of, res[63], res == 64'd0};
               r.next_pc    = arch_pc + 64'd2;
               r.dest_reg   = rb;
               r.dest_value = res;
            end
            OP_JUMP: r.next_pc = cond_true(fn) ? rq.immediate : arch_pc + 64'd9;
            OP_CALL, OP_PUSH: begin
               addr = rsp - 64'd8;
               if (!quad_ok(addr)) r.status = STAT_ADR;
               else begin
                  arch_mem[addr] = (code == OP_CALL) ? arch_pc + 64'd9 : va;
                  r.mem_written  = 1'b1;
                  r.mem_address  = addr[19:0];
                  r.dest_reg     = REG_RSP;
                  r.dest_value   = addr;
                  r.next_pc      = (code == OP_CALL) ? rq.immediate : arch_pc + 64'd2;
               end
            end
            OP_RET: begin
               if (!quad_ok(rsp)) r.status = STAT_ADR;
               else begin
                  r.next_pc    = mem_read(rsp);
                  r.dest_reg   = REG_RSP;
                  r.dest_value = rsp + 64'd8;
               end
            end
            default: begin
               if (!quad_ok(rsp)) r.status = STAT_ADR;
               else begin
                  arch_regs[REG_RSP] = rsp + 64'd8;
                  r.dest_reg   = ra;
                  r.dest_value = mem_read(rsp);
                  r.next_pc    = arch_pc + 64'd2;
               end
            end
         endcase
      end
      if (r.status == STAT_INS || r.status == STAT_ADR) begin
         r.next_pc     = arch_pc;
         r.dest_reg    = REG_NONE;
         r.dest_value  = 64'd0;
         r.mem_written = 1'b0;
         r.mem_address = 20'd0;
      end
      if (r.dest_reg != REG_NONE) arch_regs[r.dest_reg] = r.dest_value;
      arch_pc = r.next_pc;
      r.zero_flag     = arch_flags[0];
      r.sign_flag     = arch_flags[1];
      r.overflow_flag = arch_flags[2];
      if (r.mem_written) stored_addrs.push_back({44'd0, r.mem_address});
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // No gap half of the time, mostly a short one otherwise, sometimes a long one.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Sends one request: the predictor runs when the block accepts it. Valid
   // stays high after the accepting edge so that a request with no gap can
   // follow at once; a gap or release_request drops it.
   task automatic send_request(input logic [7:0] op, input logic [7:0] regs,
                               input logic [63:0] imm);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{operation: op, reg_byte: regs, immediate: imm};
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(execute_instr(req_payload));
   endtask

   // Stops offering requests after the last accepted one.
   task automatic release_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver stall pattern; a long hold can be forced by the stimulus side.
   initial begin
      int g;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         g = gap_len();
         if (g == 0 && !hold_rsp) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (g + 1) @(posedge clock);
            while (hold_rsp) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Each accepted response is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", rsp_payload.next_pc, 64'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.status != want.status)
               report_mismatch("status", rsp_payload.status, want.status);
            if (rsp_payload.next_pc != want.next_pc)
               report_mismatch("next_pc", rsp_payload.next_pc, want.next_pc);
            if (rsp_payload.dest_reg != want.dest_reg)
               report_mismatch("dest_reg", rsp_payload.dest_reg, want.dest_reg);
            if (rsp_payload.dest_value != want.dest_value)
               report_mismatch("dest_value", rsp_payload.dest_value, want.dest_value);
            if (rsp_payload.zero_flag != want.zero_flag)
               report_mismatch("zero_flag", rsp_payload.zero_flag, want.zero_flag);
            if (rsp_payload.sign_flag != want.sign_flag)
               report_mismatch("sign_flag", rsp_payload.sign_flag, want.sign_flag);
            if (rsp_payload.overflow_flag != want.overflow_flag)
               report_mismatch("overflow_flag", rsp_payload.overflow_flag,
                               want.overflow_flag);
            if (rsp_payload.mem_written != want.mem_written)
               report_mismatch("mem_written", rsp_payload.mem_written, want.mem_written);
            if (rsp_payload.mem_address != want.mem_address)
               report_mismatch("mem_address", rsp_payload.mem_address, want.mem_address);
         end
      end
   end

   function automatic logic [7:0] rr(input logic [3:0] a, input logic [3:0] b);
      return {a, b};
   endfunction

   // A random general register other than rsp, so the stack stays sane.
   function automatic logic [3:0] any_reg();
      logic [3:0] r;
      r = 4'($urandom_range(0, 13));
      if (r >= REG_RSP) r++;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7FFF_FFFF_FFFF_FFFF;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // A quad address that has been stored, for loads.
   function automatic logic [63:0] written_addr();
      return stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
   endfunction

   function automatic logic [63:0] good_addr();
      return {44'd0, 17'($urandom), 3'd0};
   endfunction

   task automatic wait_drained();
      release_request();
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // Extremes of the fields, each operation and each special case.
   task automatic test_directed();
      send_request({OP_HALT, 4'h0}, 8'hFF, 64'd0);
      send_request({OP_NOP, 4'h0}, 8'hFF, '1);
      send_request({OP_IRMOV, 4'h0}, rr(REG_NONE, 4'd0), 64'h7FFF_FFFF_FFFF_FFFF);
      send_request({OP_IRMOV, 4'h0}, rr(REG_NONE, 4'd14), 64'd1);
      // Signed overflow on add, then on subtract.
      send_request({OP_ALU, ALU_ADD}, rr(4'd14, 4'd0), 64'd0);
      send_request({OP_ALU, ALU_SUB}, rr(4'd0, 4'd14), 64'd0);
      send_request({OP_ALU, ALU_AND}, rr(4'd0, 4'd0), 64'd0);
      send_request({OP_ALU, ALU_XOR}, rr(4'd0, 4'd0), 64'd0);
      // Condition moves and jumps, taken and not taken.
      send_request({OP_CMOV, CC_EQ}, rr(4'd14, 4'd1), 64'd0);
      send_request({OP_CMOV, CC_NE}, rr(4'd14, 4'd2), 64'd0);
      send_request({OP_JUMP, CC_GT}, 8'hFF, 64'h100);
      send_request({OP_JUMP, CC_EQ}, 8'hFF, '1);
      // Stores, loads and the stack.
      send_request({OP_RMMOV, 4'h0}, rr(4'd14, REG_NONE), 64'(MEM_BYTES - 8));
      send_request({OP_MRMOV, 4'h0}, rr(4'd3, 4'd0), 64'(MEM_BYTES - 8));
      send_request({OP_PUSH, 4'h0}, rr(4'd14, REG_NONE), 64'd0);
      send_request({OP_CALL, 4'h0}, 8'hFF, 64'h40);
      send_request({OP_RET, 4'h0}, 8'hFF, 64'd0);
      send_request({OP_POP, 4'h0}, rr(REG_RSP, REG_NONE), 64'd0);
      // Address errors: unaligned and past the end of memory.
      send_request({OP_RMMOV, 4'h0}, rr(4'd1, 4'd1), 64'd4);
      send_request({OP_MRMOV, 4'h0}, rr(4'd1, 4'd1), 64'(MEM_BYTES));
      // Invalid codes and functions, the last one with an invalid register as well.
      send_request({4'hC, 4'h0}, 8'h00, 64'd0);
      send_request({4'hF, 4'hF}, 8'h00, 64'd0);
      send_request({OP_NOP, 4'h1}, 8'h00, 64'd0);
      send_request({OP_ALU, 4'h4}, 8'h00, 64'd0);
      send_request({OP_CMOV, 4'h7}, rr(4'd0, REG_NONE), 64'd0);
   endtask

   // Drives rsp to zero, past the end of memory and to an unaligned value to hit stack address errors.
   task automatic test_stack_limits();
      send_request({OP_IRMOV, 4'h0}, rr(REG_NONE, REG_RSP), 64'd0);
      send_request({OP_PUSH, 4'h0}, rr(4'd1, REG_NONE), 64'd0);
      send_request({OP_CALL, 4'h0}, 8'hFF, 64'd0);
      send_request({OP_IRMOV, 4'h0}, rr(REG_NONE, REG_RSP), 64'(MEM_BYTES));
      send_request({OP_RET, 4'h0}, 8'hFF, 64'd0);
      send_request({OP_POP, 4'h0}, rr(4'd1, REG_NONE), 64'd0);
      send_request({OP_IRMOV, 4'h0}, rr(REG_NONE, REG_RSP), 64'd3);
      send_request({OP_POP, 4'h0}, rr(4'd1, REG_NONE), 64'd0);
      send_request({OP_IRMOV, 4'h0}, rr(REG_NONE, REG_RSP), RSP_RESET);
   endtask

   // The receiver holds off while requests keep coming, filling the block.
   task automatic test_backpressure();
      int i;
      hold_rsp = 1'b1;
      fork
         begin
            repeat (40) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            for (i = 0; i < 6; i++)
               send_request({OP_ALU, 2'd0, 2'($urandom)}, rr(any_reg(), any_reg()),
                            64'd0);
            release_request();
         end
      join
      wait_drained();
   endtask

   // One random instruction, or a push/pop or call/ret pair; mostly well-formed, some noise.
   task automatic send_random();
      logic [3:0]  ra, rb;
      logic [63:0] rsp;
      int          p;
      ra  = any_reg();
      rb  = any_reg();
      rsp = arch_regs[REG_RSP];
      p   = $urandom_range(0, 99);
      if (p < 10) begin
         // Raw noise; loads from unwritten memory are avoided.
         case ($urandom_range(0, 2))
            0: send_request({4'($urandom_range(12, 15)), 4'($urandom)}, 8'($urandom),
                            rand64());
            1: send_request({OP_HALT, 4'($urandom_range(1, 15))}, 8'($urandom), rand64());
            default: send_request({OP_RMMOV, 4'h0}, 8'($urandom),
                                  $urandom_range(0, 1) ? rand64() : good_addr());
         endcase
      end else if (p < 14) begin
         send_request({$urandom_range(0, 1) ? OP_CMOV : OP_ALU, 4'h0},
                      $urandom_range(0, 1) ? rr(ra, REG_NONE) : rr(REG_NONE, rb), 64'd0);
      end else if (p < 34) begin
         send_request({OP_ALU, 2'd0, 2'($urandom)}, rr(ra, rb), 64'd0);
      end else if (p < 44) begin
         send_request({OP_IRMOV, 4'h0}, rr(4'($urandom), rb), rand64());
      end else if (p < 52) begin
         send_request({OP_CMOV, 4'($urandom_range(0, 6))}, rr(ra, rb), 64'd0);
      end else if (p < 58) begin
         send_request({OP_JUMP, 4'($urandom_range(0, 6))}, 8'($urandom), rand64());
      end else if (p < 68) begin
         send_request({OP_RMMOV, 4'h0}, rr(ra, 4'($urandom)), good_addr());
      end else if (p < 76) begin
         if (stored_addrs.size() != 0)
            send_request({OP_MRMOV, 4'h0}, rr(ra, 4'($urandom)), written_addr());
         else
            send_request({OP_NOP, 4'h0}, 8'($urandom), rand64());
      end else if (p < 84) begin
         send_request({OP_PUSH, 4'h0}, rr(ra, 4'($urandom)), 64'd0);
         send_request({OP_POP, 4'h0}, rr(any_reg(), 4'($urandom)), 64'd0);
      end else if (p < 90) begin
         send_request({OP_CALL, 4'h0}, 8'($urandom), rand64());
         send_request({OP_RET, 4'h0}, 8'($urandom), 64'd0);
      end else if (p < 94) begin
         send_request({OP_NOP, 4'h0}, 8'($urandom), rand64());
      end else if (p < 97) begin
         send_request({OP_HALT, 4'h0}, 8'($urandom), rand64());
      end else begin
         // Bad displacement for a store or load.
         send_request({$urandom_range(0, 1) ? OP_RMMOV : OP_MRMOV, 4'h0}, rr(ra, rb),
                      good_addr() + 64'($urandom_range(1, 7)));
      end
   endtask

   task automatic test_random();
      int i;
      for (i = 0; i < 420; i++) begin
         send_random();
         // Once in a while the sender waits until all responses are in.
         if (i % 120 == 60) wait_drained();
      end
   endtask

   initial begin
      int i;
      error_count = 0;
      hold_rsp    = 1'b0;
      for (i = 0; i < 15; i++) arch_regs[i] = 64'd0;
      arch_regs[REG_RSP] = RSP_RESET;
      arch_flags  = 3'd0;
      arch_pc     = 64'd0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_stack_limits();
      test_backpressure();
      test_random();

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/y86_pkg.sv
rtl/core/y86_regs.sv
rtl/core/y86_dmem.sv
rtl/core/y86_exec.sv
rtl/core/y86_64_instruction_executor.sv
rtl/core/y86_checker.sv
dv/tb_top.sv
